// ===== rtl/assert_macros.svh =====
// Assertion macros for the site update RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define HMSU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");
// Expression must never be true outside reset
`define HMSU_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: label");
`else
`define HMSU_ASSERT(label, clk, rst_n, prop)
`define HMSU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/hmsu_pkg.sv =====
// Types, constants and table builders for the Heisenberg Metropolis site update.
// Depends on nothing; used by every module of the block but the RAM.
`timescale 1ns / 1ps
package hmsu_pkg;

    localparam int LAT_SIDE    = 16;
    localparam int TRIG_BITS   = 10;
    localparam int EXP_ENTRIES = 3072;
    localparam int EXP_AW      = 12;
    localparam int EXP_W       = 17;
    localparam int WORD_W      = 80;
    localparam int APB_AW      = 4;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic signed [15:0] FIELD_RST = 16'sd4096;
    localparam logic signed [15:0] NEAR_RST  = 16'sd4096;
    localparam logic signed [15:0] NEXT_RST  = 16'sd2048;
    localparam logic [15:0]        BETA_RST  = 16'd256;

    typedef enum logic [1:0] {
        REG_FIELD = 2'd0,
        REG_NEAR  = 2'd1,
        REG_NEXT  = 2'd2,
        REG_BETA  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ANG_LOAD  = 2'd0,
        ANG_THETA = 2'd1,
        ANG_PHI   = 2'd2
    } ang_sel_t;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  site_x;
        logic [3:0]  site_y;
        logic [3:0]  site_z;
        logic [15:0] prop_theta;
        logic [15:0] new_phi;
        logic [15:0] draw_theta;
        logic [15:0] draw_phi;
    } in_item_t;

    typedef struct packed {
        logic               theta_taken;
        logic               phi_taken;
        logic signed [23:0] energy_change;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic              fill_we;
        logic [EXP_AW-1:0] fill_addr;
        logic              rd_en;
        logic [3:0]        rd_idx;
        logic              loc_mul;
        logic              loc_add;
        logic [1:0]        comp;
        logic              cand_lut;
        logic              cand_mul;
        ang_sel_t          ang_sel;
        logic              delta;
        logic              acc_clr;
        logic              pp_mul;
        logic              pp_acc;
        logic [2:0]        pp_step;
        logic              de_calc;
        logic              beta_calc;
        logic              decide;
        logic              trial;
        logic              load_wr;
        logic              out_load;
    } cmd_t;

    // Quarter-wave sine entry in Q1.14, odd Taylor series in Q30
    function automatic logic [14:0] sine_entry(input int unsigned i, input int unsigned tb);
        longint unsigned q;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint signed   sum;
        q = 64'd1 << (tb - 2);
        x = (64'(i) * PI_Q30 + q) >> (tb - 1);
        x2 = (x * x) >> 30;
        term = x;
        sum = signed'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
        end
        if (sum < 0) sum = 0;
        v = (unsigned'(sum) + 64'd32768) >> 16;
        if (v > 64'd16384) v = 64'd16384;
        return v[14:0];
    endfunction

    // exp(-1/256) in Q30, eight series terms
    function automatic logic [30:0] exp_ratio();
        longint signed   r;
        longint unsigned term;
        r = 64'sd1073741824;
        term = 64'd1073741824;
        for (int k = 1; k <= 8; k++) begin
            term = term / 64'(256 * k);
            if ((k % 2) == 1) r = r - signed'(term);
            else r = r + signed'(term);
        end
        return r[30:0];
    endfunction

endpackage

// ===== rtl/hmsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the lattice store and the exponential table.
`timescale 1ns / 1ps
module hmsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hmsu_ctrl.sv =====
// Sequencer for the site update: table fill, load writes, neighbor gather, two trials, result.
// Depends on hmsu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hmsu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_is_load,
    output logic            s_ready,
    input  logic            m_ready,
    output logic            m_valid,
    output hmsu_pkg::cmd_t  cmd
);

    typedef enum logic [17:0] {
        ST_FILL    = 18'b000000000000000001,
        ST_IDLE    = 18'b000000000000000010,
        ST_RD      = 18'b000000000000000100,
        ST_RD_TAIL = 18'b000000000000001000,
        ST_LOC_MUL = 18'b000000000000010000,
        ST_LOC_ADD = 18'b000000000000100000,
        ST_CAND_A  = 18'b000000000001000000,
        ST_CAND_B  = 18'b000000000010000000,
        ST_LOAD_W  = 18'b000000000100000000,
        ST_DELTA   = 18'b000000001000000000,
        ST_PP      = 18'b000000010000000000,
        ST_DE      = 18'b000000100000000000,
        ST_BETA    = 18'b000001000000000000,
        ST_EXPRD   = 18'b000010000000000000,
        ST_DECIDE  = 18'b000100000000000000,
        ST_DONE    = 18'b001000000000000000
    } state_t;

    localparam int RD_LAST = 14;
    localparam int PP_LAST = 6;

    state_t                        state_reg, state_next;
    logic [hmsu_pkg::EXP_AW-1:0]   fill_cnt_reg, fill_cnt_next;
    logic [3:0]                    rd_cnt_reg, rd_cnt_next;
    logic [1:0]                    comp_reg, comp_next;
    logic [2:0]                    pp_cnt_reg, pp_cnt_next;
    logic                          trial_reg, trial_next;
    logic                          load_reg, load_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and command decode
    always_comb begin
        state_next    = state_reg;
        fill_cnt_next = fill_cnt_reg;
        rd_cnt_next   = rd_cnt_reg;
        comp_next     = comp_reg;
        pp_cnt_next   = pp_cnt_reg;
        trial_next    = trial_reg;
        load_next     = load_reg;
        cmd           = '0;
        cmd.fill_addr = fill_cnt_reg;
        cmd.rd_idx    = rd_cnt_reg;
        cmd.comp      = comp_reg;
        cmd.pp_step   = pp_cnt_reg;
        cmd.trial     = trial_reg;
        cmd.ang_sel   = load_reg ? hmsu_pkg::ANG_LOAD :
                        (trial_reg ? hmsu_pkg::ANG_PHI : hmsu_pkg::ANG_THETA);
        unique case (state_reg)
            ST_FILL: begin
                cmd.fill_we = 1'b1;
                if (fill_cnt_reg == hmsu_pkg::EXP_AW'(hmsu_pkg::EXP_ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start   = 1'b1;
                    load_next   = s_is_load;
                    trial_next  = 1'b0;
                    rd_cnt_next = '0;
                    state_next  = s_is_load ? ST_CAND_A : ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd_en = 1'b1;
                if (rd_cnt_reg == 4'(RD_LAST)) begin
                    state_next = ST_RD_TAIL;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
            end
            ST_RD_TAIL: begin
                comp_next  = '0;
                state_next = ST_LOC_MUL;
            end
            ST_LOC_MUL: begin
                cmd.loc_mul = 1'b1;
                state_next  = ST_LOC_ADD;
            end
            ST_LOC_ADD: begin
                cmd.loc_add = 1'b1;
                if (comp_reg == 2'd2) begin
                    state_next = ST_CAND_A;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_LOC_MUL;
                end
            end
            ST_CAND_A: begin
                cmd.cand_lut = 1'b1;
                state_next   = ST_CAND_B;
            end
            ST_CAND_B: begin
                cmd.cand_mul = 1'b1;
                state_next   = load_reg ? ST_LOAD_W : ST_DELTA;
            end
            ST_LOAD_W: begin
                cmd.load_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DELTA: begin
                cmd.delta   = 1'b1;
                cmd.acc_clr = 1'b1;
                pp_cnt_next = '0;
                state_next  = ST_PP;
            end
            ST_PP: begin
                cmd.pp_mul = (pp_cnt_reg != 3'(PP_LAST));
                cmd.pp_acc = (pp_cnt_reg != 3'd0);
                if (pp_cnt_reg == 3'(PP_LAST)) begin
                    state_next = ST_DE;
                end else begin
                    pp_cnt_next = pp_cnt_reg + 1'b1;
                end
            end
            ST_DE: begin
                cmd.de_calc = 1'b1;
                state_next  = ST_BETA;
            end
            ST_BETA: begin
                cmd.beta_calc = 1'b1;
                state_next    = ST_EXPRD;
            end
            ST_EXPRD: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (trial_reg) begin
                    state_next = ST_DONE;
                end else begin
                    trial_next = 1'b1;
                    state_next = ST_CAND_A;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Advance control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            fill_cnt_reg <= '0;
            rd_cnt_reg   <= '0;
            comp_reg     <= '0;
            pp_cnt_reg   <= '0;
            trial_reg    <= 1'b0;
            load_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
            rd_cnt_reg   <= rd_cnt_next;
            comp_reg     <= comp_next;
            pp_cnt_reg   <= pp_cnt_next;
            trial_reg    <= trial_next;
            load_reg     <= load_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    `HMSU_ASSERT(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_ready))
    `HMSU_ASSERT_NEVER(a_rd_range, aclk, aresetn, (state_reg == ST_RD) && (rd_cnt_reg > 4'(RD_LAST)))
    `HMSU_ASSERT(a_decide_wait, aclk, aresetn, (state_reg == ST_DECIDE) |-> ($past(state_reg) == ST_EXPRD))

endmodule

// ===== rtl/hmsu_datapath.sv =====
// Datapath of the site update: lattice store, neighbor sums, local fields,
// trial energy, Boltzmann table. Depends on hmsu_pkg and hmsu_ram.
`timescale 1ns / 1ps
module hmsu_datapath #(
    parameter int SIDE            = hmsu_pkg::LAT_SIDE,
    parameter int TRIG_TABLE_BITS = hmsu_pkg::TRIG_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hmsu_pkg::cmd_t       cmd,
    input  hmsu_pkg::in_item_t   s_data,
    input  logic signed [15:0]   cfg_field,
    input  logic signed [15:0]   cfg_near,
    input  logic signed [15:0]   cfg_next,
    input  logic [15:0]          cfg_beta,
    output hmsu_pkg::out_item_t  m_data
);

    localparam int TB      = TRIG_TABLE_BITS;
    localparam int QUARTER = 1 << (TB - 2);
    localparam int CW      = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int SITES   = SIDE * SIDE * SIDE;
    localparam int AW      = $clog2(SITES);
    localparam int NB_NEAR = 6;
    localparam int NB_ALL  = 14;
    localparam logic [30:0] EXP_R = hmsu_pkg::exp_ratio();

    // Quarter-wave sine table, built at elaboration
    logic [14:0] sine_rom [QUARTER+1];
    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_sine
        assign sine_rom[gi] = hmsu_pkg::sine_entry(gi, TB);
    end

    function automatic logic signed [15:0] sine_at(input logic [TB-1:0] j);
        logic [TB-2:0]      ridx;
        logic signed [15:0] m;
        if (j[TB-2]) ridx = (TB-1)'(QUARTER) - {1'b0, j[TB-3:0]};
        else ridx = {1'b0, j[TB-3:0]};
        m = signed'({1'b0, sine_rom[ridx]});
        return j[TB-1] ? -m : m;
    endfunction

    function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [31:0] p;
        p = a * b + 32'sd8192;
        return p[29:14];
    endfunction

    function automatic logic [CW-1:0] wrap_coord(input logic [3:0] v);
        logic [6:0] r;
        r = {3'b000, v};
        for (int k = 0; k < 8; k++) begin
            if (r >= 7'(SIDE)) r = r - 7'(SIDE);
        end
        return r[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return AW'((int'(x) * SIDE + int'(y)) * SIDE + int'(z));
    endfunction

    hmsu_pkg::in_item_t item_reg;
    logic [CW-1:0]      xs_reg, ys_reg, zs_reg;
    logic [15:0]        site_theta_reg, site_phi_reg;
    logic signed [15:0] site_c_reg [3];
    logic signed [18:0] near_reg [3];
    logic signed [19:0] next_reg [3];
    logic [3:0]         tag_reg;
    logic               tag_v_reg;
    logic signed [34:0] pnear_reg;
    logic signed [35:0] pnext_reg;
    logic signed [33:0] local_reg [3];
    logic signed [15:0] st_reg, ct_reg, sp_reg, cp_reg;
    logic [15:0]        cand_theta_reg, cand_phi_reg;
    logic signed [15:0] cand_c_reg [3];
    logic signed [16:0] delta_reg [3];
    logic signed [51:0] prod_reg, acc_reg;
    logic signed [26:0] de_reg;
    logic [hmsu_pkg::EXP_AW-1:0] idx_reg;
    logic               idx_ok_reg;
    logic signed [27:0] total_reg;
    logic               t_ok_reg, p_ok_reg;
    logic [30:0]        cur_reg;
    hmsu_pkg::out_item_t out_reg;

    // Neighbor coordinates with periodic wrap
    logic [CW-1:0] xl, xh, yl, yh, zl, zh, ax, ay, az;
    always_comb begin
        xl = (xs_reg == '0) ? CW'(SIDE - 1) : xs_reg - CW'(1);
        xh = (xs_reg == CW'(SIDE - 1)) ? '0 : xs_reg + CW'(1);
        yl = (ys_reg == '0) ? CW'(SIDE - 1) : ys_reg - CW'(1);
        yh = (ys_reg == CW'(SIDE - 1)) ? '0 : ys_reg + CW'(1);
        zl = (zs_reg == '0) ? CW'(SIDE - 1) : zs_reg - CW'(1);
        zh = (zs_reg == CW'(SIDE - 1)) ? '0 : zs_reg + CW'(1);
        ax = xs_reg;
        ay = ys_reg;
        az = zs_reg;
        unique case (cmd.rd_idx)
            4'd0:  ax = xl;
            4'd1:  ax = xh;
            4'd2:  ay = yl;
            4'd3:  ay = yh;
            4'd4:  az = zl;
            4'd5:  az = zh;
            4'd6:  begin ax = xl; az = zl; end
            4'd7:  begin ay = yl; az = zl; end
            4'd8:  begin ax = xh; az = zl; end
            4'd9:  begin ay = yh; az = zl; end
            4'd10: begin ax = xl; az = zh; end
            4'd11: begin ay = yl; az = zh; end
            4'd12: begin ax = xh; az = zh; end
            4'd13: begin ay = yh; az = zh; end
            default: ;
        endcase
    end

    // Lattice store: theta, phi, x, y, z in one word
    logic                        lat_we;
    logic [hmsu_pkg::WORD_W-1:0] lat_wdata, lat_rdata;
    logic                        take;
    logic [hmsu_pkg::EXP_W-1:0]  exp_rdata, exp_wdata, boltz;
    logic                        de_pos;

    assign lat_we    = cmd.load_wr || (cmd.decide && take);
    assign lat_wdata = {cand_theta_reg, cand_phi_reg, cand_c_reg[0], cand_c_reg[1],
                        cand_c_reg[2]};

    hmsu_ram #(.WIDTH(hmsu_pkg::WORD_W), .DEPTH(SITES)) u_lattice (
        .aclk  (aclk),
        .we    (lat_we),
        .waddr (site_addr(xs_reg, ys_reg, zs_reg)),
        .wdata (lat_wdata),
        .raddr (site_addr(ax, ay, az)),
        .rdata (lat_rdata)
    );

    // Boltzmann factor table, filled by recurrence after reset
    logic [61:0] fill_prod;
    assign fill_prod = cur_reg * EXP_R;
    assign exp_wdata = hmsu_pkg::EXP_W'((cur_reg + 31'd8192) >> 14);

    hmsu_ram #(.WIDTH(hmsu_pkg::EXP_W), .DEPTH(hmsu_pkg::EXP_ENTRIES)) u_exp (
        .aclk  (aclk),
        .we    (cmd.fill_we),
        .waddr (cmd.fill_addr),
        .wdata (exp_wdata),
        .raddr (idx_reg),
        .rdata (exp_rdata)
    );

    // Local field terms for one component
    logic signed [34:0] pnear_c;
    logic signed [35:0] pnext_c;
    logic signed [36:0] loc_sum;
    assign pnear_c = cfg_near * near_reg[cmd.comp];
    assign pnext_c = cfg_next * next_reg[cmd.comp];
    assign loc_sum = 37'(pnear_reg) + 37'(pnext_reg) + (37'(cfg_field) <<< 14);

    // Candidate angles and sine lookups
    logic [15:0]   ang_t, ang_p;
    logic [TB-1:0] tj, pj;
    always_comb begin
        unique case (cmd.ang_sel)
            hmsu_pkg::ANG_THETA: begin ang_t = item_reg.prop_theta; ang_p = site_phi_reg; end
            hmsu_pkg::ANG_PHI:   begin ang_t = site_theta_reg; ang_p = item_reg.new_phi; end
            default:             begin ang_t = item_reg.prop_theta; ang_p = item_reg.new_phi; end
        endcase
        tj = {1'b0, ang_t[15 -: TB-1]};
        pj = ang_p[15 -: TB];
    end

    // Partial products of delta times local field
    logic signed [16:0] d_sel;
    logic signed [33:0] l_sel;
    logic signed [34:0] p_lo;
    logic signed [33:0] p_hi;
    assign d_sel = delta_reg[cmd.pp_step[2:1]];
    assign l_sel = local_reg[cmd.pp_step[2:1]];
    assign p_lo  = d_sel * $signed({1'b0, l_sel[16:0]});
    assign p_hi  = d_sel * $signed(l_sel[33:17]);

    // Trial energy, Boltzmann index
    logic signed [52:0] de_shift;
    logic [41:0]        beta_prod;
    assign de_shift  = (53'sd33554432 - 53'(acc_reg)) >>> 26;
    assign beta_prod = cfg_beta * de_reg[25:0];

    // Acceptance decision
    assign de_pos = (de_reg > 27'sd0);
    assign boltz  = idx_ok_reg ? exp_rdata : '0;
    always_comb begin
        if (cmd.trial) take = !de_pos || ({1'b0, item_reg.draw_phi} < boltz);
        else take = !de_pos || ({1'b0, item_reg.draw_theta} <= boltz);
    end

    // Saturated total
    logic signed [23:0] total_sat;
    always_comb begin
        if (total_reg > 28'sd8388607) total_sat = 24'sd8388607;
        else if (total_reg < -28'sd8388608) total_sat = -24'sd8388608;
        else total_sat = total_reg[23:0];
    end

    // Read tag and fill recurrence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_v_reg <= 1'b0;
            cur_reg   <= 31'd1073741824;
        end else begin
            tag_v_reg <= cmd.rd_en;
            if (cmd.fill_we) begin
                cur_reg <= 31'((fill_prod + 62'd536870912) >> 30);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        tag_reg <= cmd.rd_idx;
        if (cmd.start) begin
            item_reg  <= s_data;
            xs_reg    <= wrap_coord(s_data.site_x);
            ys_reg    <= wrap_coord(s_data.site_y);
            zs_reg    <= wrap_coord(s_data.site_z);
            total_reg <= '0;
            t_ok_reg  <= 1'b0;
            p_ok_reg  <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                near_reg[c] <= '0;
                next_reg[c] <= '0;
            end
        end
        // Gather neighbor sums and the site itself
        if (tag_v_reg) begin
            if (tag_reg == 4'(NB_ALL)) begin
                site_theta_reg <= lat_rdata[79:64];
                site_phi_reg   <= lat_rdata[63:48];
                site_c_reg[0]  <= lat_rdata[47:32];
                site_c_reg[1]  <= lat_rdata[31:16];
                site_c_reg[2]  <= lat_rdata[15:0];
            end else if (tag_reg < 4'(NB_NEAR)) begin
                near_reg[0] <= near_reg[0] + 19'($signed(lat_rdata[47:32]));
                near_reg[1] <= near_reg[1] + 19'($signed(lat_rdata[31:16]));
                near_reg[2] <= near_reg[2] + 19'($signed(lat_rdata[15:0]));
            end else begin
                next_reg[0] <= next_reg[0] + 20'($signed(lat_rdata[47:32]));
                next_reg[1] <= next_reg[1] + 20'($signed(lat_rdata[31:16]));
                next_reg[2] <= next_reg[2] + 20'($signed(lat_rdata[15:0]));
            end
        end
        if (cmd.loc_mul) begin
            pnear_reg <= pnear_c;
            pnext_reg <= pnext_c;
        end
        if (cmd.loc_add) begin
            local_reg[cmd.comp] <= loc_sum[33:0];
        end
        if (cmd.cand_lut) begin
            cand_theta_reg <= ang_t;
            cand_phi_reg   <= ang_p;
            st_reg <= sine_at(tj);
            ct_reg <= sine_at(tj + TB'(QUARTER));
            sp_reg <= sine_at(pj);
            cp_reg <= sine_at(pj + TB'(QUARTER));
        end
        if (cmd.cand_mul) begin
            cand_c_reg[0] <= mul_q14(st_reg, cp_reg);
            cand_c_reg[1] <= mul_q14(st_reg, sp_reg);
            cand_c_reg[2] <= ct_reg;
        end
        if (cmd.delta) begin
            for (int c = 0; c < 3; c++) begin
                delta_reg[c] <= 17'(cand_c_reg[c]) - 17'(site_c_reg[c]);
            end
        end
        if (cmd.pp_mul) begin
            prod_reg <= cmd.pp_step[0] ? (52'(p_hi) <<< 17) : 52'(p_lo);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.pp_acc) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.de_calc) begin
            de_reg <= de_shift[26:0];
        end
        if (cmd.beta_calc) begin
            idx_reg    <= beta_prod[14 +: hmsu_pkg::EXP_AW];
            idx_ok_reg <= (beta_prod[41:14] < 28'(hmsu_pkg::EXP_ENTRIES));
        end
        // Commit an accepted move
        if (cmd.decide && take) begin
            total_reg      <= total_reg + 28'(de_reg);
            site_theta_reg <= cand_theta_reg;
            site_phi_reg   <= cand_phi_reg;
            for (int c = 0; c < 3; c++) begin
                site_c_reg[c] <= cand_c_reg[c];
            end
            if (cmd.trial) p_ok_reg <= 1'b1;
            else t_ok_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            out_reg.theta_taken   <= t_ok_reg;
            out_reg.phi_taken     <= p_ok_reg;
            out_reg.energy_change <= total_sat;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/heisenberg_metropolis_site_update_core.sv =====
// Top level of the Heisenberg Metropolis site update: APB registers,
// sequencer and datapath. Depends on hmsu_pkg, hmsu_ctrl, hmsu_datapath.
`timescale 1ns / 1ps
// After reset the block fills its Boltzmann factor table and holds
// s_ready low meanwhile; register writes are taken at any time. A load
// word runs the candidate lookup, the candidate product and the lattice
// write. A proposal word does the fourteen neighbor reads and the site read
// through the single lattice read port, the local fields, and two trials,
// each with serial partial products and a registered exponential table read.
// One word is worked at a time; the result register lets the next word be
// taken while a result waits. A site must be loaded before it or any of its
// neighbors is used in a proposal.
module heisenberg_metropolis_site_update_core #(
    parameter int SIDE            = hmsu_pkg::LAT_SIDE,
    parameter int TRIG_TABLE_BITS = hmsu_pkg::TRIG_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hmsu_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hmsu_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hmsu_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic signed [15:0] field_reg, near_reg, next_reg;
    logic [15:0]        beta_reg;
    hmsu_pkg::reg_idx_t reg_sel;
    hmsu_pkg::cmd_t     cmd;

    assign pready  = 1'b1;
    assign reg_sel = hmsu_pkg::reg_idx_t'(paddr[3:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg <= hmsu_pkg::FIELD_RST;
            near_reg  <= hmsu_pkg::NEAR_RST;
            next_reg  <= hmsu_pkg::NEXT_RST;
            beta_reg  <= hmsu_pkg::BETA_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                hmsu_pkg::REG_FIELD: field_reg <= pwdata[15:0];
                hmsu_pkg::REG_NEAR:  near_reg  <= pwdata[15:0];
                hmsu_pkg::REG_NEXT:  next_reg  <= pwdata[15:0];
                default:             beta_reg  <= pwdata[15:0];
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_sel)
            hmsu_pkg::REG_FIELD: prdata = {16'h0000, field_reg};
            hmsu_pkg::REG_NEAR:  prdata = {16'h0000, near_reg};
            hmsu_pkg::REG_NEXT:  prdata = {16'h0000, next_reg};
            default:             prdata = {16'h0000, beta_reg};
        endcase
    end

    hmsu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_load (s_data.req_type),
        .s_ready   (s_ready),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .cmd       (cmd)
    );

    hmsu_datapath #(
        .SIDE            (SIDE),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_field (field_reg),
        .cfg_near  (near_reg),
        .cfg_next  (next_reg),
        .cfg_beta  (beta_reg),
        .m_data    (m_data)
    );

endmodule

// ===== tb/heisenberg_metropolis_site_update_core_tb.sv =====
// Self-checking testbench for the Heisenberg Metropolis site update core.
// Depends on hmsu_pkg and heisenberg_metropolis_site_update_core; a built-in predictor scores each word.
`timescale 1ns / 1ps
module heisenberg_metropolis_site_update_core_tb;
    import hmsu_pkg::*;

    localparam logic REQ_PROPOSE = 1'b0;
    localparam logic REQ_LOAD    = 1'b1;
    localparam int   NSITES      = 4096;
    localparam int   WATCH_LIMIT = 20000;
    localparam int   ITEMS_PER_PHASE = 456;

    // site itself, six near neighbors, eight further neighbors
    localparam int DX[15] = '{0, -1, 1, 0, 0, 0, 0, -1, 0, 1, 0, -1, 0, 1, 0};
    localparam int DY[15] = '{0, 0, 0, -1, 1, 0, 0, 0, -1, 0, 1, 0, -1, 0, 1};
    localparam int DZ[15] = '{0, 0, 0, 0, 0, -1, 1, -1, -1, -1, -1, 1, 1, 1, 1};

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic      pready;

    heisenberg_metropolis_site_update_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic int site_of(int x, int y, int z);
        return (((x & 15) * 16) + (y & 15)) * 16 + (z & 15);
    endfunction

    // Lattice predictor and queue of expected result words
    class spin_update_scoreboard;
        int          errors;
        int          proposals;
        int          theta_moves;
        int          phi_moves;
        out_item_t   expected_q[$];
        int          sine_q[257];
        longint      boltz[3072];
        int          h_field;
        int          j_near;
        int          j_next;
        int          beta;
        int          sx[NSITES];
        int          sy[NSITES];
        int          sz[NSITES];
        int          ang_t[NSITES];
        int          ang_p[NSITES];

        function new();
            longint unsigned x, x2, term, v, cur, t2;
            longint          acc, r;
            for (int i = 0; i <= 256; i++) begin
                x = (longint'(i) * 64'd3373259426 + 256) / 512;
                x2 = (x * x) >> 30;
                term = x;
                acc = longint'(x);
                for (int k = 1; k <= 7; k++) begin
                    term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    acc = (k % 2) ? acc - longint'(term) : acc + longint'(term);
                end
                if (acc < 0) acc = 0;
                v = (longint'(acc) + 32768) >> 16;
                if (v > 16384) v = 16384;
                sine_q[i] = int'(v);
            end
            r = 64'sd1 << 30;
            t2 = 64'd1 << 30;
            for (int k = 1; k <= 8; k++) begin
                t2 = t2 / longint'(256 * k);
                r = (k % 2) ? r - longint'(t2) : r + longint'(t2);
            end
            cur = 64'd1 << 30;
            for (int i = 0; i < 3072; i++) begin
                boltz[i] = longint'((cur + 8192) >> 14);
                cur = (cur * longint'(r) + (64'd1 << 29)) >> 30;
            end
            h_field = 4096;
            j_near = 4096;
            j_next = 2048;
            beta = 256;
        endfunction

        function void set_reg(reg_idx_t idx, logic [15:0] v);
            case (idx)
                REG_FIELD: h_field = int'(signed'(v));
                REG_NEAR:  j_near = int'(signed'(v));
                REG_NEXT:  j_next = int'(signed'(v));
                default:   beta = int'(v);
            endcase
        endfunction

        function int sine(int j);
            int q, r;
            j = j & 1023;
            q = j >> 8;
            r = j & 255;
            case (q)
                0: return sine_q[r];
                1: return sine_q[256 - r];
                2: return -sine_q[r];
                default: return -sine_q[256 - r];
            endcase
        endfunction

        function int round_q14(int a, int b);
            longint p;
            p = longint'(a) * b + 8192;
            return int'(p >>> 14);
        endfunction

        function void spin_of(int tc, int pc, output int cx, output int cy, output int cz);
            int st, ct, sp, cp;
            st = sine(tc >> 7);
            ct = sine((tc >> 7) + 256);
            sp = sine(pc >> 6);
            cp = sine((pc >> 6) + 256);
            cx = round_q14(st, cp);
            cy = round_q14(st, sp);
            cz = ct;
        endfunction

        function void store(int s, int tc, int pc);
            int cx, cy, cz;
            spin_of(tc, pc, cx, cy, cz);
            ang_t[s] = tc;
            ang_p[s] = pc;
            sx[s] = cx;
            sy[s] = cy;
            sz[s] = cz;
        endfunction

        function longint energy_delta(int s, longint lx, longint ly, longint lz, int tc, int pc);
            int cx, cy, cz;
            longint acc;
            spin_of(tc, pc, cx, cy, cz);
            acc = longint'(cx - sx[s]) * lx + longint'(cy - sy[s]) * ly
                + longint'(cz - sz[s]) * lz;
            return (-acc + (64'sd1 << 25)) >>> 26;
        endfunction

        function longint factor(longint de);
            longint unsigned idx;
            idx = (longint'(beta) * de) >> 14;
            return (idx < 3072) ? boltz[idx] : 0;
        endfunction

        // Predict the result word for an accepted input word
        function void note_input(in_item_t it);
            out_item_t exp_w;
            int s, n;
            longint lsum[3], near_s, next_s, de, total;
            exp_w = '0;
            s = site_of(it.site_x, it.site_y, it.site_z);
            if (it.req_type == REQ_LOAD) begin
                store(s, it.prop_theta, it.new_phi);
            end else begin
                proposals++;
                for (int c = 0; c < 3; c++) begin
                    near_s = 0;
                    next_s = 0;
                    for (int k = 1; k < 15; k++) begin
                        n = site_of(it.site_x + DX[k], it.site_y + DY[k], it.site_z + DZ[k]);
                        if (k < 7) near_s += (c == 0) ? sx[n] : (c == 1) ? sy[n] : sz[n];
                        else next_s += (c == 0) ? sx[n] : (c == 1) ? sy[n] : sz[n];
                    end
                    lsum[c] = longint'(j_near) * near_s + longint'(j_next) * next_s
                            + longint'(h_field) * 16384;
                end
                total = 0;
                de = energy_delta(s, lsum[0], lsum[1], lsum[2], it.prop_theta, ang_p[s]);
                if (de <= 0 || longint'(it.draw_theta) <= factor(de)) begin
                    exp_w.theta_taken = 1'b1;
                    theta_moves++;
                    total += de;
                    store(s, it.prop_theta, ang_p[s]);
                end
                de = energy_delta(s, lsum[0], lsum[1], lsum[2], ang_t[s], it.new_phi);
                if (de <= 0 || longint'(it.draw_phi) < factor(de)) begin
                    exp_w.phi_taken = 1'b1;
                    phi_moves++;
                    total += de;
                    store(s, ang_t[s], it.new_phi);
                end
                if (total > 8388607) total = 8388607;
                if (total < -8388608) total = -8388608;
                exp_w.energy_change = total[23:0];
            end
            expected_q.push_back(exp_w);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        endtask

        // Compare a result word with the oldest prediction
        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result word", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.theta_taken !== want.theta_taken)
                report_mismatch("theta_taken", got.theta_taken, want.theta_taken);
            if (got.phi_taken !== want.phi_taken)
                report_mismatch("phi_taken", got.phi_taken, want.phi_taken);
            if (got.energy_change !== want.energy_change)
                report_mismatch("energy_change", got.energy_change, want.energy_change);
        endtask
    endclass

    spin_update_scoreboard sb;
    bit  loaded[NSITES];
    int  send_idle;
    int  recv_idle;
    int  hold_left;
    int  words_sent;
    int  quiet_cycles;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall timeout: count cycles with no word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("heisenberg_metropolis_site_update_core_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: check accepted words, then pick the next ready value
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_word(in_item_t it);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        words_sent++;
        if (it.req_type == REQ_LOAD) loaded[site_of(it.site_x, it.site_y, it.site_z)] = 1'b1;
    endtask

    task automatic load_site(int x, int y, int z, logic [15:0] th, logic [15:0] ph);
        in_item_t it;
        it = in_item_t'{REQ_LOAD, 4'(x), 4'(y), 4'(z), th, ph, 16'($urandom), 16'($urandom)};
        send_word(it);
    endtask

    // Load any unloaded site of the neighborhood, then propose
    task automatic propose(int x, int y, int z, logic [15:0] th, logic [15:0] ph,
                           logic [15:0] dt, logic [15:0] dp);
        in_item_t it;
        for (int k = 0; k < 15; k++) begin
            if (!loaded[site_of(x + DX[k], y + DY[k], z + DZ[k])])
                load_site((x + DX[k]) & 15, (y + DY[k]) & 15, (z + DZ[k]) & 15,
                          16'($urandom), 16'($urandom));
        end
        it = in_item_t'{REQ_PROPOSE, 4'(x), 4'(y), 4'(z), th, ph, dt, dp};
        send_word(it);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [15:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{16{v[15]}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        int base_x, base_y, base_z, goal;
        logic [15:0] fv, nv, xv, bv;
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        send_idle = 36;
        recv_idle = 70;
        hold_left = 0;
        words_sent = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) wait_drained();
            // Register settings: defaults, extremes, zero beta, random, small beta
            case (phase)
                0: begin fv = 16'd4096; nv = 16'd4096; xv = 16'd2048; bv = 16'd256; end
                1: begin fv = 16'h8000; nv = 16'h7FFF; xv = 16'h8000; bv = 16'hFFFF; end
                2: begin fv = 16'h7FFF; nv = 16'h8000; xv = 16'h7FFF; bv = 16'd0; end
                3: begin fv = $urandom; nv = $urandom; xv = $urandom; bv = $urandom; end
                default: begin fv = $urandom; nv = $urandom; xv = $urandom;
                               bv = $urandom_range(1, 64); end
            endcase
            reg_write(REG_FIELD, fv);
            reg_write(REG_NEAR, nv);
            reg_write(REG_NEXT, xv);
            reg_write(REG_BETA, bv);
            case (phase % 3)
                0: begin send_idle = 36; recv_idle = 70; end
                1: begin send_idle = 70; recv_idle = 36; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            // Long result-side stall while input keeps coming
            if (phase == 2) hold_left = 700;

            if (phase == 0) begin
                // Corner site with wrapping neighbors and extreme angles and draws
                load_site(0, 0, 0, 16'hFFFF, 16'hFFFF);
                propose(0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                propose(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                propose(15, 15, 15, 16'h8000, 16'h4000, 16'hFFFF, 16'h0000);
                propose(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
                load_site(15, 15, 15, 16'h0000, 16'h0000);
                propose(15, 15, 15, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
            end

            base_x = $urandom_range(15);
            base_y = $urandom_range(15);
            base_z = $urandom_range(15);
            goal = words_sent + ((phase == 4) ? ITEMS_PER_PHASE / 4 : ITEMS_PER_PHASE);
            while (words_sent < goal) begin
                if ($urandom_range(99) < 8) begin
                    load_site($urandom_range(15), $urandom_range(15), $urandom_range(15),
                              16'($urandom), 16'($urandom));
                end else begin
                    propose((base_x + $urandom_range(3)) & 15, (base_y + $urandom_range(3)) & 15,
                            (base_z + $urandom_range(3)) & 15, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
                end
            end
        end

        wait_drained();
        $display("covered %0d words: %0d proposals, %0d polar and %0d azimuth moves taken",
                 words_sent, sb.proposals, sb.theta_moves, sb.phi_moves);
        $display("five register settings including extremes; %0d mismatches", sb.errors);
        if (sb.errors == 0)
            $display("heisenberg_metropolis_site_update_core_tb: done, clean");
        else
            $display("heisenberg_metropolis_site_update_core_tb: done, errors");
        $finish;
    end
endmodule
